// File: sv/modulated_reflectance_sensor_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the reflectance sensor detector
// Clocked property wrappers used by the RTL assertion blocks.
// ----------------------------------------------------------------------------
`ifndef MODULATED_REFLECTANCE_SENSOR_DETECTOR_ASSERT_SVH
`define MODULATED_REFLECTANCE_SENSOR_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define MRSD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mrsd assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MRSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mrsd assertion failed");

`endif

// File: sv/mrsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrsd_pkg
// Shared sizes, phase codes and register indexes of the sensor detector.
// ----------------------------------------------------------------------------
package mrsd_pkg;

    localparam int SENSOR_COUNT = 4;
    localparam int SAMPLE_BITS  = 10;
    localparam int THRESH_BITS  = 10;

    // Common width for comparing a difference against a threshold
    localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

    // Stream payload widths, padded to whole bytes
    localparam int S_DATA_BITS = ((SENSOR_COUNT * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((1 + SENSOR_COUNT + 7) / 8) * 8;
    localparam int M_USER_BITS = 2;

    // Phase codes
    localparam logic [1:0] PH_LIT    = 2'd0;
    localparam logic [1:0] PH_DARK   = 2'd1;
    localparam logic [1:0] PH_PROC   = 2'd2;
    localparam logic [1:0] PH_UNUSED = 2'd3;

    // Configuration register indexes
    localparam logic REG_ON_THRESHOLD  = 1'b0;
    localparam logic REG_OFF_THRESHOLD = 1'b1;

    // Event kinds
    localparam logic KIND_ON_TAPE  = 1'b0;
    localparam logic KIND_OFF_TAPE = 1'b1;

    localparam logic [THRESH_BITS-1:0] ON_THRESHOLD_RESET  = THRESH_BITS'(600);
    localparam logic [THRESH_BITS-1:0] OFF_THRESHOLD_RESET = THRESH_BITS'(900);

    typedef logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] sample_vec_t;
    typedef logic [SENSOR_COUNT-1:0]                  sensor_bits_t;

    // Thresholds handed to the classifier
    typedef struct packed {
        logic [THRESH_BITS-1:0] on_thresh;
        logic [THRESH_BITS-1:0] off_thresh;
    } thresh_t;

endpackage
`default_nettype wire

// File: sv/modulated_reflectance_sensor_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modulated_reflectance_sensor_detector
// Synchronous lit/dark detection of four reflectance sensors with hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per timer event. s_tuser[0] is the tick flag,
//   s_tdata carries the four samples. A tick steps the lit, dark and process
//   phases; a non-tick leaves all state alone.
//   m_ channel: exactly one transaction per input transaction, giving the
//   emitter level, the sensor bits and, on the process phase, a tape event.
//   cfg channel: writes the on threshold (index 0) and off threshold
//   (index 1); always ready, meant to be used while the block is idle.
// Timing: the result is registered and appears in the cycle after the input
//   transaction. Rate: one transaction per cycle while m_tready is high, set by the
//   single output register; the four subtract-compare paths sit in front of it.
// Reset: synchronous, active low. Phase returns to lit, emitter lit, bits
//   cleared, thresholds 600 and 900. No clearing pass is needed.
// Stall: while m_tready is low the held result stays and s_tready drops;
//   a new input is taken in the same cycle that the held result leaves.
// ----------------------------------------------------------------------------
`include "modulated_reflectance_sensor_detector_assert.svh"

module modulated_reflectance_sensor_detector (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // input stream
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [mrsd_pkg::S_DATA_BITS-1:0]     s_tdata,   // sample_0..sample_3
    input  wire                                  s_tuser,   // is_tick
    // result stream
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [mrsd_pkg::M_DATA_BITS-1:0]     m_tdata,   // emitter_on, sensor_bits, pad
    output logic [mrsd_pkg::M_USER_BITS-1:0]     m_tuser,   // event_valid, event_kind
    // configuration writes
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire                                  cfg_index,
    input  wire  [mrsd_pkg::THRESH_BITS-1:0]     cfg_data
);

    localparam int NS = mrsd_pkg::SENSOR_COUNT;
    localparam int SB = mrsd_pkg::SAMPLE_BITS;

    // State
    logic [1:0]                 phase_reg,   phase_next;
    logic                       emitter_reg, emitter_next;
    mrsd_pkg::sensor_bits_t     cur_reg,     cur_next;
    mrsd_pkg::sensor_bits_t     rep_reg,     rep_next;
    mrsd_pkg::sample_vec_t      lit_reg;
    mrsd_pkg::sample_vec_t      dark_reg;
    mrsd_pkg::thresh_t          thresh_reg;

    // Result register
    logic                       out_valid_reg, out_valid_next;
    logic                       ev_valid_reg,  ev_valid_next;
    logic                       ev_kind_reg,   ev_kind_next;

    logic                       s_accept;
    mrsd_pkg::sample_vec_t      samples;
    mrsd_pkg::sensor_bits_t     class_bits;

    // Output register frees up when it is empty or being drained
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        for (int i = 0; i < NS; i++) begin
            samples[i] = s_tdata[i*SB +: SB];
        end
    end

    mrsd_classify u_classify (
        .lit      (lit_reg),
        .dark     (dark_reg),
        .thresh   (thresh_reg),
        .cur_bits (cur_reg),
        .rep_bits (rep_reg),
        .new_bits (class_bits)
    );

    // Phase sequencing and event decision
    always_comb begin
        phase_next    = phase_reg;
        emitter_next  = emitter_reg;
        cur_next      = cur_reg;
        rep_next      = rep_reg;
        ev_valid_next = ev_valid_reg;
        ev_kind_next  = ev_kind_reg;
        if (s_accept) begin
            ev_valid_next = 1'b0;
            ev_kind_next  = mrsd_pkg::KIND_ON_TAPE;
            if (s_tuser) begin
                unique case (phase_reg)
                    mrsd_pkg::PH_DARK: begin
                        phase_next = mrsd_pkg::PH_PROC;
                    end
                    mrsd_pkg::PH_PROC: begin
                        cur_next = class_bits;
                        if (class_bits > rep_reg) begin
                            ev_valid_next = 1'b1;
                            ev_kind_next  = mrsd_pkg::KIND_ON_TAPE;
                            rep_next      = class_bits;
                        end else if (class_bits < rep_reg) begin
                            ev_valid_next = 1'b1;
                            ev_kind_next  = mrsd_pkg::KIND_OFF_TAPE;
                            rep_next      = class_bits;
                        end
                        emitter_next = 1'b1;
                        phase_next   = mrsd_pkg::PH_LIT;
                    end
                    default: begin
                        // lit phase; the unused code behaves the same
                        emitter_next = 1'b0;
                        phase_next   = mrsd_pkg::PH_DARK;
                    end
                endcase
            end
        end
    end

    // Result valid handshake
    always_comb begin
        if (s_accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg             <= mrsd_pkg::PH_LIT;
            emitter_reg           <= 1'b1;
            cur_reg               <= '0;
            rep_reg               <= '0;
            out_valid_reg         <= 1'b0;
            thresh_reg.on_thresh  <= mrsd_pkg::ON_THRESHOLD_RESET;
            thresh_reg.off_thresh <= mrsd_pkg::OFF_THRESHOLD_RESET;
        end else begin
            phase_reg     <= phase_next;
            emitter_reg   <= emitter_next;
            cur_reg       <= cur_next;
            rep_reg       <= rep_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    mrsd_pkg::REG_ON_THRESHOLD:  thresh_reg.on_thresh  <= cfg_data;
                    mrsd_pkg::REG_OFF_THRESHOLD: thresh_reg.off_thresh <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Sample stores and result payload
    always_ff @(posedge aclk) begin
        ev_valid_reg <= ev_valid_next;
        ev_kind_reg  <= ev_kind_next;
        if (s_accept && s_tuser) begin
            if (phase_reg == mrsd_pkg::PH_DARK) begin
                dark_reg <= samples;
            end else if (phase_reg == mrsd_pkg::PH_LIT || phase_reg == mrsd_pkg::PH_UNUSED) begin
                lit_reg <= samples;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = mrsd_pkg::M_DATA_BITS'({cur_reg, emitter_reg});
    assign m_tuser  = {ev_kind_reg, ev_valid_reg};

    // Checks
    `MRSD_ASSERT_NOW(a_emitter_follows_phase, aclk, aresetn, 1'b1,
                     emitter_reg == (phase_reg == mrsd_pkg::PH_LIT))
    `MRSD_ASSERT_NOW(a_reported_tracks_current, aclk, aresetn, 1'b1, rep_reg == cur_reg)
    `MRSD_ASSERT_NEXT(a_lit_tick_goes_dark, aclk, aresetn,
                      s_accept && s_tuser && phase_reg == mrsd_pkg::PH_LIT,
                      !emitter_reg && phase_reg == mrsd_pkg::PH_DARK)
    `MRSD_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_tready)

endmodule
`default_nettype wire

// File: sv/mrsd_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrsd_classify
// Per-sensor lit minus dark difference with a two-threshold hysteresis band.
// ----------------------------------------------------------------------------
module mrsd_classify (
    input  wire  mrsd_pkg::sample_vec_t  lit,
    input  wire  mrsd_pkg::sample_vec_t  dark,
    input  wire  mrsd_pkg::thresh_t      thresh,
    input  wire  mrsd_pkg::sensor_bits_t cur_bits,
    input  wire  mrsd_pkg::sensor_bits_t rep_bits,
    output mrsd_pkg::sensor_bits_t       new_bits
);

    logic [mrsd_pkg::SENSOR_COUNT-1:0][mrsd_pkg::CMP_BITS-1:0] diff;
    logic [mrsd_pkg::CMP_BITS-1:0] on_ext;
    logic [mrsd_pkg::CMP_BITS-1:0] off_ext;

    assign on_ext  = mrsd_pkg::CMP_BITS'(thresh.on_thresh);
    assign off_ext = mrsd_pkg::CMP_BITS'(thresh.off_thresh);

    // One independent subtract and compare per sensor
    always_comb begin
        for (int i = 0; i < mrsd_pkg::SENSOR_COUNT; i++) begin
            diff[i] = mrsd_pkg::CMP_BITS'(lit[i]) - mrsd_pkg::CMP_BITS'(dark[i]);
            priority if (dark[i] > lit[i]) begin
                new_bits[i] = 1'b0;          // dark above lit reads as off tape
            end else if (diff[i] < on_ext) begin
                new_bits[i] = 1'b1;
            end else if (diff[i] > off_ext) begin
                new_bits[i] = 1'b0;
            end else begin
                new_bits[i] = cur_bits[i] | rep_bits[i];  // inside the band
            end
        end
    end

endmodule
`default_nettype wire

// File: bench/modulated_reflectance_sensor_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modulated_reflectance_sensor_detector_tb
// Self-checking bench for the lit/dark tape sensor detector. A cycle-level
// predictor follows every accepted tick and threshold write, and each result
// transaction is compared field by field against the oldest prediction while
// both stream sides gap and stall at random.
// ----------------------------------------------------------------------------
module modulated_reflectance_sensor_detector_tb;

    localparam int SAMPLE_MAX = (1 << mrsd_pkg::SAMPLE_BITS) - 1;
    localparam int THRESH_MAX = (1 << mrsd_pkg::THRESH_BITS) - 1;

    // One result transaction, unpacked
    typedef struct {
        logic                   emitter_on;
        logic                   event_valid;
        logic                   event_kind;
        mrsd_pkg::sensor_bits_t sensor_bits;
    } tape_report_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [mrsd_pkg::S_DATA_BITS-1:0] s_tdata = '0;   // sample_0..sample_3
    logic                             s_tuser = 1'b0; // is_tick
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [mrsd_pkg::M_DATA_BITS-1:0] m_tdata;        // emitter_on, sensor_bits, pad
    logic [mrsd_pkg::M_USER_BITS-1:0] m_tuser;        // event_valid, event_kind
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic                             cfg_index = mrsd_pkg::REG_ON_THRESHOLD;
    logic [mrsd_pkg::THRESH_BITS-1:0] cfg_data = '0;

    // Predictor state
    logic [1:0]                       det_phase = mrsd_pkg::PH_LIT;
    mrsd_pkg::sample_vec_t            lit_samples = '0;
    mrsd_pkg::sample_vec_t            dark_samples = '0;
    mrsd_pkg::sensor_bits_t           cur_bits = '0;
    mrsd_pkg::sensor_bits_t           rep_bits = '0;
    logic                             emitter = 1'b1;
    logic [mrsd_pkg::THRESH_BITS-1:0] on_thresh = mrsd_pkg::ON_THRESHOLD_RESET;
    logic [mrsd_pkg::THRESH_BITS-1:0] off_thresh = mrsd_pkg::OFF_THRESHOLD_RESET;

    tape_report_t           pending_reports[$];
    int                     mismatch_count = 0;
    int                     ticks_sent = 0;
    bit                     sender_gaps = 1'b0;
    bit                     receiver_stalls = 1'b0;

    modulated_reflectance_sensor_detector DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Run limit
    initial begin
        #5_000_000;
        $display("[modulated_reflectance_sensor_detector] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Advance the detector by one input transaction and return its result
    function automatic tape_report_t step_detector(input logic tick,
                                                   input mrsd_pkg::sample_vec_t smp);
        tape_report_t                  r;
        logic [mrsd_pkg::CMP_BITS-1:0] diff;
        r.event_valid = 1'b0;
        r.event_kind  = mrsd_pkg::KIND_ON_TAPE;
        if (tick) begin
            case (det_phase)
                mrsd_pkg::PH_DARK: begin
                    dark_samples = smp;
                    det_phase = mrsd_pkg::PH_PROC;
                end
                mrsd_pkg::PH_PROC: begin
                    for (int i = 0; i < mrsd_pkg::SENSOR_COUNT; i++) begin
                        if (dark_samples[i] > lit_samples[i]) begin
                            cur_bits[i] = 1'b0;
                        end else begin
                            diff = mrsd_pkg::CMP_BITS'(lit_samples[i] - dark_samples[i]);
                            if (diff < mrsd_pkg::CMP_BITS'(on_thresh))
                                cur_bits[i] = 1'b1;
                            else if (diff > mrsd_pkg::CMP_BITS'(off_thresh))
                                cur_bits[i] = 1'b0;
                            else
                                cur_bits[i] = cur_bits[i] | rep_bits[i];
                        end
                    end
                    if (cur_bits > rep_bits) begin
                        r.event_valid = 1'b1;
                        r.event_kind  = mrsd_pkg::KIND_ON_TAPE;
                        rep_bits = cur_bits;
                    end else if (cur_bits < rep_bits) begin
                        r.event_valid = 1'b1;
                        r.event_kind  = mrsd_pkg::KIND_OFF_TAPE;
                        rep_bits = cur_bits;
                    end
                    emitter = 1'b1;
                    det_phase = mrsd_pkg::PH_LIT;
                end
                // lit phase; the unused code behaves the same
                default: begin
                    lit_samples = smp;
                    emitter = 1'b0;
                    det_phase = mrsd_pkg::PH_DARK;
                end
            endcase
        end
        r.emitter_on  = emitter;
        r.sensor_bits = cur_bits;
        return r;
    endfunction

    // Scoreboard: follows config writes and inputs, checks every result
    always @(posedge aclk) begin : scoreboard
        tape_report_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mrsd_pkg::REG_ON_THRESHOLD:  on_thresh  = cfg_data;
                    mrsd_pkg::REG_OFF_THRESHOLD: off_thresh = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_reports.push_back(
                    step_detector(s_tuser, mrsd_pkg::sample_vec_t'(s_tdata)));
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch("result with none pending", 1, 0);
                end else begin
                    want = pending_reports.pop_front();
                    if (m_tdata[0] !== want.emitter_on)
                        report_mismatch("emitter_on", m_tdata[0], want.emitter_on);
                    if (m_tdata[mrsd_pkg::SENSOR_COUNT:1] !== want.sensor_bits)
                        report_mismatch("sensor_bits", m_tdata[mrsd_pkg::SENSOR_COUNT:1],
                                        want.sensor_bits);
                    if (m_tuser[0] !== want.event_valid)
                        report_mismatch("event_valid", m_tuser[0], want.event_valid);
                    if (m_tuser[1] !== want.event_kind)
                        report_mismatch("event_kind", m_tuser[1], want.event_kind);
                end
            end
        end
    end

    // Receiver back-pressure in random bursts
    initial begin
        forever begin
            @(negedge aclk);
            if (receiver_stalls && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Send one input transaction, with an optional gap in front
    task automatic send_item(input logic tick, input mrsd_pkg::sample_vec_t smp);
        @(negedge aclk);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = tick;
        s_tdata  = mrsd_pkg::S_DATA_BITS'(smp);
        do @(posedge aclk); while (!s_tready);
        if (tick)
            ticks_sent++;
    endtask

    // Stop sending and wait until every predicted result has arrived
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_threshold(input logic idx,
                                   input logic [mrsd_pkg::THRESH_BITS-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_thresholds(input int on_val, input int off_val);
        drain_results();
        write_threshold(mrsd_pkg::REG_ON_THRESHOLD, mrsd_pkg::THRESH_BITS'(on_val));
        write_threshold(mrsd_pkg::REG_OFF_THRESHOLD, mrsd_pkg::THRESH_BITS'(off_val));
    endtask

    function automatic mrsd_pkg::sample_vec_t sensor_vec(input int s0, input int s1,
                                                         input int s2, input int s3);
        mrsd_pkg::sample_vec_t v;
        v[0] = mrsd_pkg::SAMPLE_BITS'(s0);
        v[1] = mrsd_pkg::SAMPLE_BITS'(s1);
        v[2] = mrsd_pkg::SAMPLE_BITS'(s2);
        v[3] = mrsd_pkg::SAMPLE_BITS'(s3);
        return v;
    endfunction

    function automatic mrsd_pkg::sample_vec_t rand_samples();
        mrsd_pkg::sample_vec_t v;
        for (int i = 0; i < mrsd_pkg::SENSOR_COUNT; i++) begin
            case ($urandom_range(0, 7))
                0:       v[i] = '0;
                1:       v[i] = '1;
                default: v[i] = mrsd_pkg::SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
            endcase
        end
        return v;
    endfunction

    // Lit/dark pair whose difference lands in a chosen threshold region
    task automatic targeted_pair(output logic [mrsd_pkg::SAMPLE_BITS-1:0] lit,
                                 output logic [mrsd_pkg::SAMPLE_BITS-1:0] dark);
        int on_v;
        int off_v;
        int diff;
        int d;
        on_v  = int'(on_thresh);
        off_v = int'(off_thresh);
        diff  = $urandom_range(0, SAMPLE_MAX);
        case ($urandom_range(0, 5))
            0: if (on_v > 0) diff = $urandom_range(0, on_v - 1);
            1: if (on_v <= off_v) diff = $urandom_range(on_v, off_v);
            2: if (off_v < SAMPLE_MAX) diff = $urandom_range(off_v + 1, SAMPLE_MAX);
            3: begin
                // dark brighter than lit
                lit  = mrsd_pkg::SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX - 1));
                dark = mrsd_pkg::SAMPLE_BITS'($urandom_range(int'(lit) + 1, SAMPLE_MAX));
                return;
            end
            4: begin
                // right on a threshold edge
                case ($urandom_range(0, 3))
                    0: d = on_v;
                    1: d = on_v - 1;
                    2: d = off_v;
                    default: d = off_v + 1;
                endcase
                diff = (d < 0) ? 0 : (d > SAMPLE_MAX) ? SAMPLE_MAX : d;
            end
            default: ;
        endcase
        dark = mrsd_pkg::SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX - diff));
        lit  = mrsd_pkg::SAMPLE_BITS'(int'(dark) + diff);
    endtask

    // One lit/dark/process cycle, realigned to the lit phase first
    task automatic run_cycle(input mrsd_pkg::sample_vec_t lit,
                             input mrsd_pkg::sample_vec_t dark,
                             input int noise_pct);
        while (ticks_sent % 3 != 0)
            send_item(1'b1, rand_samples());
        send_item(1'b1, lit);
        if ($urandom_range(0, 99) < noise_pct)
            send_item(1'b0, rand_samples());
        send_item(1'b1, dark);
        if ($urandom_range(0, 99) < noise_pct)
            send_item(1'b0, rand_samples());
        send_item(1'b1, rand_samples());
    endtask

    task automatic random_cycle(input int noise_pct);
        mrsd_pkg::sample_vec_t lit;
        mrsd_pkg::sample_vec_t dark;
        for (int i = 0; i < mrsd_pkg::SENSOR_COUNT; i++)
            targeted_pair(lit[i], dark[i]);
        run_cycle(lit, dark, noise_pct);
    endtask

    // Non-ticks right after reset: emitter lit, no bits, no event
    task automatic test_reset_state();
        send_item(1'b0, sensor_vec(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
        send_item(1'b0, sensor_vec(0, 0, 0, 0));
    endtask

    // Hand-picked cycles at the default thresholds 600 / 900
    task automatic test_hysteresis_edges();
        // all zero difference: every bit rises
        run_cycle(sensor_vec(0, 0, 0, 0), sensor_vec(0, 0, 0, 0), 100);
        // full scale, dark over lit, and both band edges holding a reported bit
        run_cycle(sensor_vec(SAMPLE_MAX, 0, 600, 1000),
                  sensor_vec(0, SAMPLE_MAX, 0, 100), 100);
        // just under on, just over off on two sensors, in band
        run_cycle(sensor_vec(599, 901, SAMPLE_MAX, 700), sensor_vec(0, 0, 122, 100), 0);
        // every set bit falls
        run_cycle(sensor_vec(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX),
                  sensor_vec(0, 0, 0, 0), 0);
        // in band with nothing reported: stays clear, no event
        run_cycle(sensor_vec(700, 700, 700, 700), sensor_vec(0, 0, 0, 0), 0);
        // one sensor with lit equal to dark rises
        run_cycle(sensor_vec(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX),
                  sensor_vec(SAMPLE_MAX, 0, 0, 0), 0);
    endtask

    // Threshold extremes, including on above off where the on test wins
    task automatic test_threshold_extremes();
        int settings[7][2];
        settings = '{'{0, 0}, '{THRESH_MAX, THRESH_MAX}, '{THRESH_MAX, 0},
                     '{0, THRESH_MAX}, '{1, THRESH_MAX - 1}, '{300, 310}, '{600, 900}};
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        foreach (settings[k]) begin
            set_thresholds(settings[k][0], settings[k][1]);
            repeat (12)
                random_cycle(15);
        end
    endtask

    // Long random run, thresholds moved now and then, quiet tail at the end
    task automatic test_random_traffic();
        int start_ticks;
        int done;
        int lo;
        start_ticks = ticks_sent;
        done = 0;
        while (done < 1150) begin
            if (done >= 1000) begin
                sender_gaps     = 1'b0;
                receiver_stalls = 1'b0;
            end else if (done % 400 < 3 && done > 0) begin
                lo = $urandom_range(0, 900);
                set_thresholds(lo, $urandom_range(lo, THRESH_MAX));
                sender_gaps     = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 19))
                0, 1:    send_item(1'b0, rand_samples());
                2:       send_item(1'b1, rand_samples());
                default: random_cycle(10);
            endcase
            done = ticks_sent - start_ticks;
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        test_reset_state();
        test_hysteresis_edges();
        test_threshold_extremes();
        test_random_traffic();
        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[modulated_reflectance_sensor_detector] OK");
        else
            $display("[modulated_reflectance_sensor_detector] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/mrsd_pkg.sv
sv/mrsd_classify.sv
sv/modulated_reflectance_sensor_detector.sv
bench/modulated_reflectance_sensor_detector_tb.sv
